>>> rtl/circle_rasterizer_assert.svh
// Assertion macros used by the circle rasterizer checker.
`ifndef CIRCLE_RASTERIZER_ASSERT_SVH
`define CIRCLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cr_pkg.sv
// Shared types and constants of the circle rasterizer.
`default_nettype none
package cr_pkg;

  // Largest radius the scan accepts; larger values saturate.
  localparam logic [9:0] MAX_RADIUS = 10'd1023;

  localparam int COORD_W  = 16;
  localparam int PIXEL_W  = 17;
  localparam int RADIUS_W = 10;
  localparam int OFFX_W   = 11;
  localparam int OFFY_W   = 12;

  // Action codes of an input transfer.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // One candidate pixel as handed from the scan sequencer to the test pipeline.
  typedef struct packed {
    logic signed [PIXEL_W-1:0]  pixel_x;
    logic signed [PIXEL_W-1:0]  pixel_y;
    logic signed [OFFX_W-1:0]   off_x;
    logic signed [OFFY_W-1:0]   off_y;
    logic [RADIUS_W-1:0]        radius;
    logic [RADIUS_W-1:0]        width;
    logic                       filled;
    logic                       last;
    logic                       idle;
  } cand_t;

endpackage
`default_nettype wire

>>> rtl/cr_scan.sv
// Scan sequencer: latches circle parameters and walks the candidate offsets.
`default_nettype none
module cr_scan (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start_take,
  input  wire logic                          step_take,
  input  wire logic signed [cr_pkg::COORD_W-1:0]  center_x,
  input  wire logic signed [cr_pkg::COORD_W-1:0]  center_y,
  input  wire logic [cr_pkg::RADIUS_W-1:0]   radius,
  input  wire logic                          filled,
  input  wire logic [cr_pkg::RADIUS_W-1:0]   ring_width,
  output cr_pkg::cand_t                      cand
);
  import cr_pkg::*;

  logic                       scan_active;
  logic signed [OFFX_W-1:0]   offset_x;
  logic signed [OFFY_W-1:0]   offset_y;
  logic signed [COORD_W-1:0]  held_center_x;
  logic signed [COORD_W-1:0]  held_center_y;
  logic [RADIUS_W-1:0]        held_radius;
  logic [RADIUS_W-1:0]        held_width;
  logic                       held_filled;

  logic [RADIUS_W-1:0]        r_clamp;
  logic [RADIUS_W-1:0]        w_limit;
  logic [RADIUS_W-1:0]        w_clamp;
  logic [RADIUS_W:0]          start_span;
  logic [RADIUS_W:0]          span;
  logic signed [OFFY_W-1:0]   span_s;
  logic                       x_end;
  logic                       y_end;
  logic                       fin;

  // Clamp radius and ring width of a start transfer
  always_comb begin
    r_clamp    = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
    w_limit    = {1'b0, r_clamp[RADIUS_W-1:1]};
    w_clamp    = (ring_width > w_limit) ? w_limit : ring_width;
    start_span = {1'b0, r_clamp} + {1'b0, w_clamp};
  end

  // Scan bounds and end detection
  always_comb begin
    span   = {1'b0, held_radius} + {1'b0, held_width};
    span_s = $signed({1'b0, span});
    x_end  = offset_x >= $signed({1'b0, held_radius});
    y_end  = offset_y >= span_s;
    fin    = x_end && y_end;
  end

  // Present the current candidate; an idle step reports the origin as last
  always_comb begin
    cand.off_x  = offset_x;
    cand.off_y  = offset_y;
    cand.radius = held_radius;
    cand.width  = held_width;
    cand.filled = held_filled;
    cand.idle   = !scan_active;
    if (scan_active) begin
      cand.pixel_x = $signed({held_center_x[COORD_W-1], held_center_x})
                   + $signed({{(PIXEL_W-OFFX_W){offset_x[OFFX_W-1]}}, offset_x});
      cand.pixel_y = $signed({held_center_y[COORD_W-1], held_center_y})
                   + $signed({{(PIXEL_W-OFFY_W){offset_y[OFFY_W-1]}}, offset_y});
      cand.last    = fin;
    end else begin
      cand.pixel_x = '0;
      cand.pixel_y = '0;
      cand.last    = 1'b1;
    end
  end

  // Latch on start, advance on step
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active   <= 1'b0;
      offset_x      <= '0;
      offset_y      <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      held_radius   <= '0;
      held_width    <= '0;
      held_filled   <= 1'b0;
    end else if (start_take) begin
      scan_active   <= 1'b1;
      held_center_x <= center_x;
      held_center_y <= center_y;
      held_radius   <= r_clamp;
      held_width    <= w_clamp;
      held_filled   <= filled;
      offset_x      <= -$signed({1'b0, r_clamp});
      offset_y      <= -$signed({1'b0, start_span});
    end else if (step_take && scan_active) begin
      if (fin) begin
        scan_active <= 1'b0;
      end else if (y_end) begin
        offset_x <= offset_x + OFFX_W'(1);
        offset_y <= -span_s;
      end else begin
        offset_y <= offset_y + OFFY_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/circle_rasterizer.sv
// Top level of the circle rasterizer: scan sequencer and pixel test pipeline.
//
//   channel  handshake          payload
//   in       in_valid/in_stall  action, center_x, center_y, radius, filled, ring_width
//   out      out_valid/out_stall pixel_x, pixel_y, plot, last
//
// One input transfer per cycle while in_stall is low; a step's result is registered in
// three registers in turn: candidate, squares and products, result.
// A start transfer gives no result. Reset clears the scan and all stage valids.
// Each stage moves when the next one is empty or moving, so an output stall
// backs up through the stages and bubbles are filled before in_stall rises.
`default_nettype none
module circle_rasterizer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic signed [cr_pkg::COORD_W-1:0]  center_x,
  input  wire logic signed [cr_pkg::COORD_W-1:0]  center_y,
  input  wire logic [cr_pkg::RADIUS_W-1:0]   radius,
  input  wire logic                          filled,
  input  wire logic [cr_pkg::RADIUS_W-1:0]   ring_width,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [cr_pkg::PIXEL_W-1:0]  pixel_x,
  output logic signed [cr_pkg::PIXEL_W-1:0]  pixel_y,
  output logic                               plot,
  output logic                               last
);
  import cr_pkg::*;

  logic    take;
  logic    start_take;
  logic    step_take;
  cand_t   cand;

  logic    s1_valid;
  cand_t   s1;
  logic    s2_valid;
  logic signed [PIXEL_W-1:0] s2_pixel_x;
  logic signed [PIXEL_W-1:0] s2_pixel_y;
  logic    s2_filled;
  logic    s2_last;
  logic    s2_idle;
  logic [20:0] s2_sq_x;
  logic [21:0] s2_sq_y;
  logic [19:0] s2_rr;
  logic [19:0] s2_rw;
  logic [RADIUS_W-1:0] s2_radius;

  logic    out_ready;
  logic    s2_ready;
  logic    s1_ready;

  logic signed [21:0] prod_x;
  logic signed [23:0] prod_y;
  logic [19:0] prod_rr;
  logic [19:0] prod_rw;
  logic [22:0] dist_sq;
  logic [19:0] ring_lo;
  logic [20:0] ring_hi;
  logic    hit;

  // Stage flow control
  always_comb begin
    out_ready = !out_valid || !out_stall;
    s2_ready  = !s2_valid || out_ready;
    s1_ready  = !s1_valid || s2_ready;
    in_stall  = !s1_ready;
    take       = in_valid && s1_ready;
    start_take = take && (action == ACT_START);
    step_take  = take && (action == ACT_STEP);
  end

  cr_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .start_take (start_take),
    .step_take  (step_take),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .filled     (filled),
    .ring_width (ring_width),
    .cand       (cand)
  );

  // Squares and radius products
  always_comb begin
    prod_x  = s1.off_x * s1.off_x;
    prod_y  = s1.off_y * s1.off_y;
    prod_rr = s1.radius * s1.radius;
    prod_rw = s1.radius * s1.width;
  end

  // Distance test
  always_comb begin
    dist_sq = {2'b00, s2_sq_x} + {1'b0, s2_sq_y};
    ring_lo = s2_rr - s2_rw;
    ring_hi = {1'b0, s2_rr} + {11'd0, s2_radius};
    if (s2_idle) begin
      hit = 1'b0;
    end else if (s2_filled) begin
      hit = dist_sq <= {3'b000, s2_rr};
    end else begin
      hit = (dist_sq >= {3'b000, ring_lo}) && (dist_sq <= {2'b00, ring_hi});
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= step_take;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (s1_ready && step_take) begin
      s1 <= cand;
    end
    if (s2_ready && s1_valid) begin
      s2_pixel_x <= s1.pixel_x;
      s2_pixel_y <= s1.pixel_y;
      s2_filled  <= s1.filled;
      s2_last    <= s1.last;
      s2_idle    <= s1.idle;
      s2_radius  <= s1.radius;
      s2_sq_x    <= prod_x[20:0];
      s2_sq_y    <= prod_y[21:0];
      s2_rr      <= prod_rr;
      s2_rw      <= prod_rw;
    end
    if (out_ready && s2_valid) begin
      pixel_x <= s2_pixel_x;
      pixel_y <= s2_pixel_y;
      plot    <= hit;
      last    <= s2_last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cr_checker.sv
// Port-level checker for the circle rasterizer, bound to the top level.
`default_nettype none
`include "circle_rasterizer_assert.svh"
module cr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          action,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [cr_pkg::PIXEL_W-1:0]  pixel_x,
  input wire logic signed [cr_pkg::PIXEL_W-1:0]  pixel_y,
  input wire logic                          plot,
  input wire logic                          last
);
  import cr_pkg::*;

  // A held result stays offered
  `CR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(plot) && $stable(last), "stalled result changed")

  // Reset empties the pipeline
  `CR_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !out_valid, "result valid after reset")

  // Input is only backed up by a held output
  `CR_ASSERT_IMPLY(a_no_idle_stall, clk, rst, !out_valid, !in_stall, "input stalled with empty output")

  // A step taken outside reset reaches the output unless an output stall holds it
  `CR_ASSERT_IMPLY(a_latency, clk, rst, $past(in_valid && !in_stall && (action == ACT_STEP), 3) && !$past(rst, 3) && !$past(rst, 2) && !$past(rst, 1) && !$past(out_valid && out_stall, 1) && !$past(out_valid && out_stall, 2), out_valid, "step result missing")

endmodule
`default_nettype wire

bind circle_rasterizer cr_checker u_cr_checker (.*);
